[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define GSCB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define GSCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gscb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscb_pkg
// Types, codes and defaults of the grouped sparse column builder.
// ----------------------------------------------------------------------------
package gscb_pkg;

    localparam int MAX_CELLS_DEF  = 1024;
    localparam int MAX_TERMS_DEF  = 4;
    localparam int MAX_GROUPS_DEF = 64;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOAD_GROUP = 2'd0,
        MODE_LOAD_TERM  = 2'd1,
        MODE_READ       = 2'd2,
        MODE_NONE       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_GROUP = 2'd1,
        ST_EXCESS    = 2'd2,
        ST_EARLY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        KIND_START   = 3'd0,
        KIND_MEMBER  = 3'd1,
        KIND_POINTER = 3'd2,
        KIND_ENTRY   = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_STARTS   = 3'd1,
        PH_MEMBERS  = 3'd2,
        PH_POINTERS = 3'd3,
        PH_ENTRIES  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT_GS,
        S_CNT_WR,
        S_SCAN_RD,
        S_SCAN_WR,
        S_FILL_RD,
        S_FILL_FP,
        S_FILL_WR,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] group;
        logic [63:0] term_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [12:0] position;
        logic [12:0] word;
        logic [63:0] value;
        logic        last;
    } out_word_t;

endpackage

[rtl/grouped_sparse_column_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_sparse_column_builder
// Counting-sort build of a compressed sparse column matrix, one column per
// (term, group) pair, with word-by-word read-out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one word: mode 0 loads the next cell's group,
//   mode 1 the next term value (term-major), mode 2 reads the next result.
//   Every accepted word gives exactly one word on out_valid/out_stall.
//   cfg_we/cfg_index/cfg_data write cell_count, term_count, group_count;
//   each write starts a new set. Write only while the block is idle.
//   A load word steps through S_PUSH, where its result moves to the output register once that frees.
//   A read steps through S_RD_A, S_RD_B and S_PUSH (group starts, members,
//   pointers) or S_RD_A, S_RD_B, S_RD_C and S_PUSH (entries, two dependent
//   memory reads); one word is worked on at a time, in_stall high meanwhile.
//   The first read after a complete load runs the counting sort first on a
//   group-start memory with one read and one write port: clear, count, prefix
//   scan and fill, in that order, set by the one read port of each memory.
//   A result waits in an output register while out_stall is high; the next
//   word is still taken, and its result holds until that register frees.
//   Reset clears the counters, the error flag and the read-out phase and
//   sets the registers to 0, 1 and 1. No memory needs clearing.
// ----------------------------------------------------------------------------
module grouped_sparse_column_builder #(
    parameter int MAX_CELLS  = gscb_pkg::MAX_CELLS_DEF,
    parameter int MAX_TERMS  = gscb_pkg::MAX_TERMS_DEF,
    parameter int MAX_GROUPS = gscb_pkg::MAX_GROUPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  gscb_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output gscb_pkg::out_word_t            out_data,
    input  logic                           cfg_we,
    input  logic [gscb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gscb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int NW   = $clog2(MAX_CELLS + 1);
    localparam int CW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int TW   = $clog2(MAX_TERMS + 1);
    localparam int NGW  = $clog2(MAX_GROUPS + 1);
    localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GSAW = $clog2(MAX_GROUPS + 1);
    localparam int TSD  = MAX_CELLS * MAX_TERMS;
    localparam int TSW  = (TSD > 1) ? $clog2(TSD) : 1;
    localparam int TLW  = $clog2(TSD + 1);
    localparam int BCM  = (MAX_CELLS > MAX_GROUPS + 1) ? MAX_CELLS : MAX_GROUPS + 1;
    localparam int BCW  = $clog2(BCM + 1);

    // configuration
    logic [10:0] cell_count_reg;
    logic [2:0]  term_count_reg;
    logic [6:0]  group_count_reg;
    logic        cfg_hit;

    logic [NW-1:0]  n;
    logic [TW-1:0]  nt;
    logic [NGW-1:0] ng;
    logic [TLW-1:0] total_terms;

    // control
    gscb_pkg::state_t  state_reg, state_next;
    gscb_pkg::phase_t  phase_reg, phase_next;
    gscb_pkg::mode_t   in_mode;
    logic [1:0]        err_reg, err_next;
    logic [NW-1:0]     cells_loaded_reg, cells_loaded_next;
    logic [TLW-1:0]    terms_loaded_reg, terms_loaded_next;
    logic [12:0]       k_reg, k_next;
    logic [TW-1:0]     t_reg, t_next;
    logic [NGW-1:0]    g_reg, g_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [TLW-1:0]    base_reg, base_next;
    logic [BCW-1:0]    bc_reg, bc_next;
    logic [NW-1:0]     acc_reg, acc_next;
    logic [CW-1:0]     cell_reg, cell_next;
    gscb_pkg::out_word_t res_reg, res_next;
    logic              res_load;
    logic              out_valid_reg;
    gscb_pkg::out_word_t out_reg;

    logic acc_in, load_done, clr_last, cnt_last, scan_last, slot_free, advance;

    // memories
    logic [GW-1:0]  cg_mem [MAX_CELLS];
    logic           cg_we;
    logic [CW-1:0]  cg_waddr, cg_raddr;
    logic [GW-1:0]  cg_wdata, cg_q;

    logic [63:0]    ts_mem [TSD];
    logic           ts_we;
    logic [TSW-1:0] ts_waddr, ts_raddr;
    logic [63:0]    ts_wdata, ts_q;

    logic [NW-1:0]   gs_mem [MAX_GROUPS + 1];
    logic            gs_we;
    logic [GSAW-1:0] gs_waddr, gs_raddr;
    logic [NW-1:0]   gs_wdata, gs_q;

    logic [NW-1:0]  fp_mem [MAX_GROUPS];
    logic           fp_we;
    logic [GW-1:0]  fp_waddr, fp_raddr;
    logic [NW-1:0]  fp_wdata, fp_q;

    logic [CW-1:0]  mb_mem [MAX_CELLS];
    logic           mb_we;
    logic [CW-1:0]  mb_waddr, mb_raddr, mb_wdata, mb_q;

    // effective sizes
    assign n  = (cell_count_reg > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(cell_count_reg);
    assign nt = (term_count_reg == 3'd0) ? TW'(1) :
                (term_count_reg > MAX_TERMS) ? TW'(MAX_TERMS) : TW'(term_count_reg);
    assign ng = (group_count_reg == 7'd0) ? NGW'(1) :
                (group_count_reg > MAX_GROUPS) ? NGW'(MAX_GROUPS) : NGW'(group_count_reg);
    assign total_terms = TLW'(n) * TLW'(nt);

    assign cfg_hit = cfg_we && (cfg_index inside {gscb_pkg::REG_CELL_COUNT,
                     gscb_pkg::REG_TERM_COUNT, gscb_pkg::REG_GROUP_COUNT});

    assign in_mode   = gscb_pkg::mode_t'(in_data.mode);
    assign acc_in    = in_valid && (state_reg == gscb_pkg::S_IDLE);
    assign load_done = (cells_loaded_reg == n) && (terms_loaded_reg == total_terms);
    assign clr_last  = (bc_reg == BCW'(ng));
    assign cnt_last  = ((bc_reg + BCW'(1)) == BCW'(n));
    assign scan_last = ((bc_reg + BCW'(1)) == BCW'(ng));
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = ((state_reg == gscb_pkg::S_RD_B) && (phase_reg != gscb_pkg::PH_ENTRIES))
                       || (state_reg == gscb_pkg::S_RD_C);

    assign in_stall  = (state_reg != gscb_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gscb_pkg::S_IDLE:
            begin
                if (acc_in)
                begin
                    if (in_mode == gscb_pkg::MODE_READ && err_reg == gscb_pkg::ST_OK &&
                        phase_reg == gscb_pkg::PH_IDLE && load_done)
                        state_next = gscb_pkg::S_CLR;
                    else if (in_mode == gscb_pkg::MODE_READ && err_reg == gscb_pkg::ST_OK &&
                             phase_reg != gscb_pkg::PH_IDLE)
                        state_next = gscb_pkg::S_RD_A;
                    else
                        state_next = gscb_pkg::S_PUSH;
                end
            end
            gscb_pkg::S_CLR:
            begin
                if (clr_last)
                    state_next = (n == '0) ? gscb_pkg::S_SCAN_RD : gscb_pkg::S_CNT_RD;
            end
            gscb_pkg::S_CNT_RD:  state_next = gscb_pkg::S_CNT_GS;
            gscb_pkg::S_CNT_GS:  state_next = gscb_pkg::S_CNT_WR;
            gscb_pkg::S_CNT_WR:
                state_next = cnt_last ? gscb_pkg::S_SCAN_RD : gscb_pkg::S_CNT_RD;
            gscb_pkg::S_SCAN_RD: state_next = gscb_pkg::S_SCAN_WR;
            gscb_pkg::S_SCAN_WR:
            begin
                if (scan_last)
                    state_next = (n == '0) ? gscb_pkg::S_RD_A : gscb_pkg::S_FILL_RD;
                else
                    state_next = gscb_pkg::S_SCAN_RD;
            end
            gscb_pkg::S_FILL_RD: state_next = gscb_pkg::S_FILL_FP;
            gscb_pkg::S_FILL_FP: state_next = gscb_pkg::S_FILL_WR;
            gscb_pkg::S_FILL_WR:
                state_next = cnt_last ? gscb_pkg::S_RD_A : gscb_pkg::S_FILL_RD;
            gscb_pkg::S_RD_A:    state_next = gscb_pkg::S_RD_B;
            gscb_pkg::S_RD_B:
                state_next = (phase_reg == gscb_pkg::PH_ENTRIES) ? gscb_pkg::S_RD_C
                                                                  : gscb_pkg::S_PUSH;
            gscb_pkg::S_RD_C:    state_next = gscb_pkg::S_PUSH;
            gscb_pkg::S_PUSH:
            begin
                if (slot_free)
                    state_next = gscb_pkg::S_IDLE;
            end
            default:             state_next = gscb_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        phase_next        = phase_reg;
        err_next          = err_reg;
        cells_loaded_next = cells_loaded_reg;
        terms_loaded_next = terms_loaded_reg;
        k_next            = k_reg;
        t_next            = t_reg;
        g_next            = g_reg;
        j_next            = j_reg;
        base_next         = base_reg;
        bc_next           = bc_reg;
        acc_next          = acc_reg;
        cell_next         = cell_reg;
        res_next          = res_reg;
        res_load          = 1'b0;

        cg_we = 1'b0; cg_waddr = CW'(cells_loaded_reg); cg_wdata = GW'(in_data.group);
        cg_raddr = CW'(bc_reg);
        ts_we = 1'b0; ts_waddr = TSW'(terms_loaded_reg); ts_wdata = in_data.term_value;
        ts_raddr = TSW'(base_reg + TLW'(mb_q));
        gs_we = 1'b0; gs_waddr = GSAW'(bc_reg); gs_wdata = '0; gs_raddr = '0;
        fp_we = 1'b0; fp_waddr = GW'(bc_reg); fp_wdata = acc_reg; fp_raddr = cg_q;
        mb_we = 1'b0; mb_waddr = CW'(fp_q); mb_wdata = CW'(bc_reg); mb_raddr = '0;

        case (phase_reg)
            gscb_pkg::PH_STARTS:   gs_raddr = GSAW'(k_reg);
            gscb_pkg::PH_MEMBERS:  mb_raddr = CW'(k_reg);
            gscb_pkg::PH_POINTERS: gs_raddr = GSAW'(g_reg);
            gscb_pkg::PH_ENTRIES:  mb_raddr = j_reg;
            default:               gs_raddr = '0;
        endcase

        case (state_reg)
            gscb_pkg::S_IDLE:
            begin
                if (acc_in)
                begin
                    res_load          = 1'b1;
                    res_next          = '0;
                    res_next.kind     = gscb_pkg::KIND_NONE;
                    res_next.status   = err_reg;
                    case (in_mode)
                        gscb_pkg::MODE_LOAD_GROUP:
                        begin
                            if (cells_loaded_reg >= n)
                            begin
                                if (err_reg == gscb_pkg::ST_OK)
                                    err_next = gscb_pkg::ST_EXCESS;
                            end
                            else
                            begin
                                if (13'(in_data.group) >= 13'(ng) &&
                                    err_reg == gscb_pkg::ST_OK)
                                    err_next = gscb_pkg::ST_BAD_GROUP;
                                cg_we             = 1'b1;
                                cells_loaded_next = cells_loaded_reg + NW'(1);
                            end
                            res_next.status = err_next;
                        end
                        gscb_pkg::MODE_LOAD_TERM:
                        begin
                            if (terms_loaded_reg >= total_terms)
                            begin
                                if (err_reg == gscb_pkg::ST_OK)
                                    err_next = gscb_pkg::ST_EXCESS;
                            end
                            else
                            begin
                                ts_we             = 1'b1;
                                terms_loaded_next = terms_loaded_reg + TLW'(1);
                            end
                            res_next.status = err_next;
                        end
                        gscb_pkg::MODE_READ:
                        begin
                            if (err_reg != gscb_pkg::ST_OK)
                            begin
                                cells_loaded_next = '0;
                                terms_loaded_next = '0;
                                phase_next        = gscb_pkg::PH_IDLE;
                                k_next            = '0;
                                err_next          = gscb_pkg::ST_OK;
                            end
                            else if (phase_reg == gscb_pkg::PH_IDLE)
                            begin
                                if (!load_done)
                                    res_next.status = gscb_pkg::ST_EARLY;
                                else
                                    bc_next = '0;
                            end
                        end
                        default: res_next.status = err_reg;
                    endcase
                end
            end
            gscb_pkg::S_CLR:
            begin
                gs_we    = 1'b1;
                acc_next = '0;
                bc_next  = clr_last ? '0 : bc_reg + BCW'(1);
            end
            gscb_pkg::S_CNT_GS:
                gs_raddr = GSAW'(cg_q) + GSAW'(1);
            gscb_pkg::S_CNT_WR:
            begin
                gs_we    = 1'b1;
                gs_waddr = GSAW'(cg_q) + GSAW'(1);
                gs_wdata = gs_q + NW'(1);
                bc_next  = cnt_last ? '0 : bc_reg + BCW'(1);
            end
            gscb_pkg::S_SCAN_RD:
                gs_raddr = GSAW'(bc_reg) + GSAW'(1);
            gscb_pkg::S_SCAN_WR:
            begin
                gs_we    = 1'b1;
                gs_waddr = GSAW'(bc_reg) + GSAW'(1);
                gs_wdata = acc_reg + gs_q;
                fp_we    = 1'b1;
                acc_next = acc_reg + gs_q;
                bc_next  = scan_last ? '0 : bc_reg + BCW'(1);
            end
            gscb_pkg::S_FILL_WR:
            begin
                mb_we    = 1'b1;
                fp_we    = 1'b1;
                fp_waddr = cg_q;
                fp_wdata = fp_q + NW'(1);
                bc_next  = cnt_last ? '0 : bc_reg + BCW'(1);
            end
            gscb_pkg::S_RD_B:
            begin
                if (phase_reg == gscb_pkg::PH_ENTRIES)
                    cell_next = mb_q;
            end
            default: res_load = 1'b0;
        endcase

        // sort finished: open the read-out
        if ((state_reg == gscb_pkg::S_SCAN_WR && scan_last && n == '0) ||
            (state_reg == gscb_pkg::S_FILL_WR && cnt_last))
        begin
            phase_next = gscb_pkg::PH_STARTS;
            k_next     = '0;
            t_next     = '0;
            g_next     = '0;
            j_next     = '0;
            base_next  = '0;
        end

        if (advance)
        begin
            res_load          = 1'b1;
            res_next          = '0;
            res_next.status   = gscb_pkg::ST_OK;
            res_next.position = k_reg;
            case (phase_reg)
                gscb_pkg::PH_STARTS:
                begin
                    res_next.kind = gscb_pkg::KIND_START;
                    res_next.word = 13'(gs_q);
                    if (k_reg == 13'(ng))
                    begin
                        k_next     = '0;
                        phase_next = (n != '0) ? gscb_pkg::PH_MEMBERS : gscb_pkg::PH_POINTERS;
                    end
                    else
                        k_next = k_reg + 13'd1;
                end
                gscb_pkg::PH_MEMBERS:
                begin
                    res_next.kind = gscb_pkg::KIND_MEMBER;
                    res_next.word = 13'(mb_q);
                    if ((k_reg + 13'd1) == 13'(n))
                    begin
                        k_next     = '0;
                        phase_next = gscb_pkg::PH_POINTERS;
                    end
                    else
                        k_next = k_reg + 13'd1;
                end
                gscb_pkg::PH_POINTERS:
                begin
                    res_next.kind = gscb_pkg::KIND_POINTER;
                    res_next.word = 13'(base_reg + TLW'(gs_q));
                    if (t_reg == nt)
                    begin
                        k_next    = '0;
                        t_next    = '0;
                        j_next    = '0;
                        base_next = '0;
                        if (n != '0)
                            phase_next = gscb_pkg::PH_ENTRIES;
                        else
                            res_next.last = 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + 13'd1;
                        if ((g_reg + NGW'(1)) == ng)
                        begin
                            g_next    = '0;
                            t_next    = t_reg + TW'(1);
                            base_next = base_reg + TLW'(n);
                        end
                        else
                            g_next = g_reg + NGW'(1);
                    end
                end
                default:
                begin
                    res_next.kind  = gscb_pkg::KIND_ENTRY;
                    res_next.word  = 13'(cell_reg);
                    res_next.value = ts_q;
                    k_next         = k_reg + 13'd1;
                    if ((NW'(j_reg) + NW'(1)) == n)
                    begin
                        j_next    = '0;
                        t_next    = t_reg + TW'(1);
                        base_next = base_reg + TLW'(n);
                        if ((t_reg + TW'(1)) == nt)
                            res_next.last = 1'b1;
                    end
                    else
                        j_next = j_reg + CW'(1);
                end
            endcase
            if (res_next.last)
            begin
                cells_loaded_next = '0;
                terms_loaded_next = '0;
                phase_next        = gscb_pkg::PH_IDLE;
                k_next            = '0;
                err_next          = gscb_pkg::ST_OK;
            end
        end

        // a register write starts a new set
        if (cfg_hit)
        begin
            cells_loaded_next = '0;
            terms_loaded_next = '0;
            phase_next        = gscb_pkg::PH_IDLE;
            k_next            = '0;
            err_next          = gscb_pkg::ST_OK;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gscb_pkg::S_IDLE;
            phase_reg        <= gscb_pkg::PH_IDLE;
            err_reg          <= gscb_pkg::ST_OK;
            cells_loaded_reg <= '0;
            terms_loaded_reg <= '0;
            k_reg            <= '0;
            t_reg            <= '0;
            g_reg            <= '0;
            j_reg            <= '0;
            base_reg         <= '0;
            bc_reg           <= '0;
            acc_reg          <= '0;
            out_valid_reg    <= 1'b0;
            cell_count_reg   <= 11'd0;
            term_count_reg   <= 3'd1;
            group_count_reg  <= 7'd1;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            err_reg          <= err_next;
            cells_loaded_reg <= cells_loaded_next;
            terms_loaded_reg <= terms_loaded_next;
            k_reg            <= k_next;
            t_reg            <= t_next;
            g_reg            <= g_next;
            j_reg            <= j_next;
            base_reg         <= base_next;
            bc_reg           <= bc_next;
            acc_reg          <= acc_next;
            if (state_reg == gscb_pkg::S_PUSH && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    gscb_pkg::REG_CELL_COUNT:  cell_count_reg  <= cfg_data;
                    gscb_pkg::REG_TERM_COUNT:  term_count_reg  <= cfg_data[2:0];
                    gscb_pkg::REG_GROUP_COUNT: group_count_reg <= cfg_data[6:0];
                    default:                   cell_count_reg  <= cell_count_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (res_load)
            res_reg <= res_next;
        if (state_reg == gscb_pkg::S_PUSH && slot_free)
            out_reg <= res_reg;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cg_we)
            cg_mem[cg_waddr] <= cg_wdata;
        cg_q <= cg_mem[cg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ts_we)
            ts_mem[ts_waddr] <= ts_wdata;
        ts_q <= ts_mem[ts_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gs_we)
            gs_mem[gs_waddr] <= gs_wdata;
        gs_q <= gs_mem[gs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fp_we)
            fp_mem[fp_waddr] <= fp_wdata;
        fp_q <= fp_mem[fp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mb_we)
            mb_mem[mb_waddr] <= mb_wdata;
        mb_q <= mb_mem[mb_raddr];
    end

endmodule

[rtl/gscb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscb_checker
// Port-level checks of the grouped sparse column builder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gscb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input gscb_pkg::in_word_t             in_data,
    input logic                           out_valid,
    input logic                           out_stall,
    input gscb_pkg::out_word_t            out_data,
    input logic                           cfg_we,
    input logic [gscb_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [gscb_pkg::CFG_W-1:0]     cfg_data
);

    `GSCB_ASSERT_ALWAYS(a_rst_quiet, clk, (!rst_n |-> !out_valid), "output valid in reset")
    `GSCB_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_data)), "stalled word changed")
    `GSCB_ASSERT(a_busy_after_take, clk, rst_n, (in_valid && !in_stall |=> in_stall), "took words in consecutive cycles")
    `GSCB_ASSERT(a_last_kind, clk, rst_n, (out_valid && out_data.last |-> out_data.status == gscb_pkg::ST_OK && (out_data.kind == gscb_pkg::KIND_POINTER || out_data.kind == gscb_pkg::KIND_ENTRY)), "last on wrong kind")
    `GSCB_ASSERT(a_none_empty, clk, rst_n, (out_valid && out_data.kind == gscb_pkg::KIND_NONE |-> out_data.position == 13'd0 && out_data.word == 13'd0 && out_data.value == 64'd0 && !out_data.last), "empty word carries data")

endmodule

bind grouped_sparse_column_builder gscb_checker u_gscb_checker (.*);
